FILE: design/soa_pkg.sv
// Shared types and constants for the slab object allocator.
package soa_pkg;

  localparam int NumSlabs  = 16;
  localparam int MaxObjs   = 512;
  localparam int MaxOrder  = 10;
  localparam int SlabW     = 4;
  localparam int LinkW     = 5;
  localparam int ObjW      = 9;
  localparam int CntW      = 10;
  localparam int SizeW     = 22;
  localparam int OrderW    = 4;
  localparam int StackAw   = SlabW + ObjW;

  localparam logic [LinkW-1:0] Nil = LinkW'(NumSlabs);

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_SHRINK  = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CL_UNUSED  = 2'd0,
    CL_EMPTY   = 2'd1,
    CL_PARTIAL = 2'd2,
    CL_FULL    = 2'd3
  } class_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLAB = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  // Derived geometry from the size register, handed to the core.
  typedef struct packed {
    logic [OrderW-1:0] order;
    logic [CntW-1:0]   objs;
    logic              valid;
  } geom_t;

endpackage

FILE: design/soa_geom.sv
// Derives slab order and objects per slab with an iterative order search and divider.
module soa_geom (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [soa_pkg::SizeW-1:0]   cfg_data,
  output logic [soa_pkg::SizeW-1:0]   obj_size,
  output soa_pkg::geom_t              geom
);

  typedef enum logic [2:0] {
    G_ORDER = 3'b001,
    G_DIV   = 3'b010,
    G_DONE  = 3'b100
  } gstate_t;

  localparam int DivW = 23;  // size + 8
  localparam int NumW = 23;  // 4096<<10 - 32 fits in 23 bits
  localparam int NeedW = 32;
  localparam int OrderW_L = soa_pkg::OrderW;

  gstate_t                    state;
  logic [OrderW_L-1:0]        ord;
  logic [DivW-1:0]            divisor;
  logic [NeedW-1:0]           need;
  logic [NumW-1:0]            rem;
  logic [NumW-1:0]            quo;
  logic [4:0]                 bitn;
  logic [NumW:0]              trial;
  logic [NeedW-1:0]           slab_bytes;

  assign slab_bytes = NeedW'(32'd4096) << ord;
  assign trial = {rem[NumW-2:0], quo[NumW-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      obj_size   <= rst ? soa_pkg::SizeW'(64) : cfg_data;
      state      <= G_ORDER;
      ord        <= '0;
      geom.valid <= 1'b0;
    end else begin
      case (state)
        G_ORDER: begin
          // advance the order one step a cycle
          if (ord < OrderW_L'(soa_pkg::MaxOrder) && slab_bytes <= need) begin
            ord <= ord + 1'b1;
          end else begin
            quo   <= NumW'(slab_bytes - 32'd32);
            rem   <= '0;
            bitn  <= 5'(NumW);
            state <= G_DIV;
          end
        end
        G_DIV: begin
          // restoring division, one quotient bit a cycle
          if (!trial[NumW]) begin
            rem <= trial[NumW-1:0];
            quo <= {quo[NumW-2:0], 1'b1};
          end else begin
            rem <= {rem[NumW-2:0], quo[NumW-1]};
            quo <= {quo[NumW-2:0], 1'b0};
          end
          bitn <= bitn - 1'b1;
          if (bitn == 5'd1) state <= G_DONE;
        end
        G_DONE: begin
          if (!geom.valid) begin
            geom.valid <= 1'b1;
            geom.order <= ord;
            geom.objs  <= (quo > NumW'(soa_pkg::MaxObjs)) ? soa_pkg::CntW'(soa_pkg::MaxObjs)
                                                         : soa_pkg::CntW'(quo);
          end
        end
        default: state <= G_ORDER;
      endcase
    end
  end

  assign divisor = DivW'(obj_size) + DivW'(8);
  assign need    = (NeedW'(divisor) << 8) + NeedW'(32);

  a_div_in_range: assert property (@(posedge clk) disable iff (rst)
    state == G_DIV |-> bitn != 5'd0) else $error("divider bit count underflow");
  a_order_cap: assert property (@(posedge clk) disable iff (rst)
    ord <= OrderW_L'(soa_pkg::MaxOrder)) else $error("order above cap");
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    geom.valid |-> state == G_DONE) else $error("geometry valid outside done");

endmodule

FILE: design/soa_core.sv
// Allocator sequencer: slab tables in registers, freed-slot stack in a memory.
module soa_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic [soa_pkg::SizeW-1:0]    obj_size,
  input  soa_pkg::geom_t               geom,
  input  logic                         start,
  input  logic [1:0]                   in_kind,
  input  logic [soa_pkg::SlabW-1:0]    in_slab,
  input  logic [soa_pkg::ObjW-1:0]     in_obj,
  output logic                         busy,
  output logic                         done,
  output logic [1:0]                   r_status,
  output logic [soa_pkg::SlabW-1:0]    r_slab,
  output logic [soa_pkg::ObjW-1:0]     r_obj,
  output logic [soa_pkg::SizeW-1:0]    r_off
);

  localparam int NS = soa_pkg::NumSlabs;
  localparam int SW = soa_pkg::SlabW;
  localparam int LW = soa_pkg::LinkW;
  localparam int OW = soa_pkg::ObjW;
  localparam int CW = soa_pkg::CntW;
  localparam int AW = soa_pkg::StackAw;
  localparam int MulW = 32;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_POP   = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_PUSH  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SHRNK = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [1:0]          cls   [NS];
  logic [CW-1:0]       fcnt  [NS];
  logic [CW-1:0]       fresh [NS];
  logic [CW-1:0]       depth [NS];
  logic [LW-1:0]       pnext [NS];
  logic [LW-1:0]       pprev [NS];
  logic [LW-1:0]       phead;

  logic [OW-1:0]       stack_mem [2**AW];
  logic [OW-1:0]       rd_data;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [OW-1:0]       wr_data;

  logic [SW-1:0]       cur;
  logic [CW-1:0]       k;
  logic                k_rd;
  logic                bad;
  logic [OW-1:0]       slot;
  logic [MulW-1:0]     prod;

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
    rd_data <= stack_mem[rd_addr];
  end

  assign busy = state != S_IDLE;

  // Linked-list helpers are written inline as remove / push on 'cur'.
  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    done  <= 1'b0;
    if (rst || clear) begin
      state <= S_IDLE;
      phead <= soa_pkg::Nil;
      for (int s = 0; s < NS; s++) begin
        cls[s]   <= soa_pkg::CL_UNUSED;
        fcnt[s]  <= '0;
        fresh[s] <= '0;
        depth[s] <= '0;
        pnext[s] <= soa_pkg::Nil;
        pprev[s] <= soa_pkg::Nil;
      end
    end else begin
      case (state)
        S_IDLE: if (start) begin
          r_status <= soa_pkg::ST_OK;
          r_slab   <= '0;
          r_obj    <= '0;
          r_off    <= '0;
          cur      <= in_slab;
          slot     <= in_obj;
          k        <= '0;
          k_rd     <= 1'b0;
          bad      <= 1'b0;
          case (in_kind)
            soa_pkg::KIND_ALLOC: begin
              if (geom.objs == '0) begin
                r_status <= soa_pkg::ST_NO_SLAB;
                state    <= S_DONE;
              end else if (phead != soa_pkg::Nil) begin
                cur <= SW'(phead);
                if (depth[SW'(phead)] != '0) begin
                  rd_addr <= {SW'(phead), OW'(depth[SW'(phead)] - 1'b1)};
                  state   <= S_POP;
                end else begin
                  slot  <= OW'(fresh[SW'(phead)]);
                  fresh[SW'(phead)] <= fresh[SW'(phead)] + 1'b1;
                  state <= S_POP;
                  k_rd  <= 1'b1;
                end
              end else begin
                cur   <= '0;
                state <= S_SCAN;
              end
            end
            soa_pkg::KIND_FREE: begin
              if (!(cls[in_slab] == soa_pkg::CL_PARTIAL || cls[in_slab] == soa_pkg::CL_FULL)
                  || CW'(in_obj) >= geom.objs || CW'(in_obj) >= fresh[in_slab]
                  || depth[in_slab] >= CW'(soa_pkg::MaxObjs)) begin
                r_status <= soa_pkg::ST_BAD;
                state    <= S_DONE;
              end else begin
                rd_addr <= {in_slab, OW'(0)};
                state   <= S_CHECK;
              end
            end
            soa_pkg::KIND_SHRINK: begin
              cur   <= '0;
              state <= S_SHRNK;
            end
            default: begin
              phead <= soa_pkg::Nil;
              for (int s = 0; s < NS; s++) begin
                cls[s]   <= soa_pkg::CL_UNUSED;
                fcnt[s]  <= '0;
                fresh[s] <= '0;
                depth[s] <= '0;
                pnext[s] <= soa_pkg::Nil;
                pprev[s] <= soa_pkg::Nil;
              end
              state <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          // walk slabs one per cycle for the lowest unused
          if (cls[cur] == soa_pkg::CL_UNUSED) begin
            depth[cur] <= '0;
            fresh[cur] <= CW'(1);
            fcnt[cur]  <= geom.objs - 1'b1;
            r_slab     <= cur;
            slot       <= '0;
            if (geom.objs == CW'(1)) begin
              cls[cur] <= soa_pkg::CL_FULL;
            end else begin
              cls[cur]   <= soa_pkg::CL_PARTIAL;
              pprev[cur] <= soa_pkg::Nil;
              pnext[cur] <= phead;
              if (phead != soa_pkg::Nil) pprev[SW'(phead)] <= LW'(cur);
              phead <= LW'(cur);
            end
            state <= S_MUL;
          end else if (cur == SW'(NS - 1)) begin
            r_status <= soa_pkg::ST_NO_SLAB;
            state    <= S_DONE;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        S_POP: begin
          // memory read data is registered and settles in the cycle after the address
          if (!k_rd) begin
            k_rd <= 1'b1;
          end else begin
            if (depth[cur] != '0 && rd_addr == {cur, OW'(depth[cur] - 1'b1)}) begin
              slot       <= rd_data;
              depth[cur] <= depth[cur] - 1'b1;
            end
            r_slab    <= cur;
            fcnt[cur] <= fcnt[cur] - 1'b1;
            if (fcnt[cur] == CW'(1)) begin
              cls[cur] <= soa_pkg::CL_FULL;
              if (pprev[cur] != soa_pkg::Nil) pnext[SW'(pprev[cur])] <= pnext[cur];
              else if (phead == LW'(cur)) phead <= pnext[cur];
              if (pnext[cur] != soa_pkg::Nil) pprev[SW'(pnext[cur])] <= pprev[cur];
              pnext[cur] <= soa_pkg::Nil;
              pprev[cur] <= soa_pkg::Nil;
            end
            state <= S_MUL;
          end
        end
        S_CHECK: begin
          // compare the stacked slots one at a time with the freed slot, each after its memory read
          if (!k_rd) begin
            k_rd <= 1'b1;
          end else if (k >= depth[cur]) begin
            state <= bad ? S_DONE : S_PUSH;
            if (bad) r_status <= soa_pkg::ST_BAD;
          end else begin
            if (rd_data == slot) bad <= 1'b1;
            k       <= k + 1'b1;
            rd_addr <= {cur, OW'(k + 1'b1)};
            k_rd    <= 1'b0;
          end
        end
        S_PUSH: begin
          wr_en      <= 1'b1;
          wr_addr    <= {cur, OW'(depth[cur])};
          wr_data    <= slot;
          depth[cur] <= depth[cur] + 1'b1;
          fcnt[cur]  <= fcnt[cur] + 1'b1;
          if (fcnt[cur] + 1'b1 >= geom.objs) begin
            if (cls[cur] == soa_pkg::CL_PARTIAL) begin
              if (pprev[cur] != soa_pkg::Nil) pnext[SW'(pprev[cur])] <= pnext[cur];
              else if (phead == LW'(cur)) phead <= pnext[cur];
              if (pnext[cur] != soa_pkg::Nil) pprev[SW'(pnext[cur])] <= pprev[cur];
              pnext[cur] <= soa_pkg::Nil;
              pprev[cur] <= soa_pkg::Nil;
            end
            cls[cur] <= soa_pkg::CL_EMPTY;
          end else if (fcnt[cur] == '0) begin
            // full slab (never on the list) goes to the list head
            cls[cur]   <= soa_pkg::CL_PARTIAL;
            pprev[cur] <= soa_pkg::Nil;
            pnext[cur] <= phead;
            if (phead != soa_pkg::Nil) pprev[SW'(phead)] <= LW'(cur);
            phead <= LW'(cur);
          end
          state <= S_DONE;
        end
        S_MUL: begin
          r_obj <= slot;
          prod  <= MulW'(slot) * MulW'(obj_size + soa_pkg::SizeW'(8));
          state <= S_DONE;
          k_rd  <= 1'b0;
          bad   <= 1'b1;
        end
        S_SHRNK: begin
          if (cls[cur] == soa_pkg::CL_EMPTY) begin
            cls[cur]   <= soa_pkg::CL_UNUSED;
            fcnt[cur]  <= '0;
            fresh[cur] <= '0;
            depth[cur] <= '0;
          end
          if (cur == SW'(NS - 1)) state <= S_DONE;
          else cur <= cur + 1'b1;
        end
        S_DONE: begin
          if (bad && r_status == soa_pkg::ST_OK)
            r_off <= soa_pkg::SizeW'(prod + MulW'(40));
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_head_class: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && phead != soa_pkg::Nil) |-> cls[SW'(phead)] == soa_pkg::CL_PARTIAL)
    else $error("list head not partial");

endmodule

FILE: design/slab_object_allocator.sv
// Top level: stream ports, output register and configuration of the slab allocator.
// Allocation uses the list head, or scans slabs for an unused one when the list is empty;
// free compares the stack (one memory read per entry); shrink walks every slab.
// Throughput: one item at a time; s_tready is low from acceptance until the result beat leaves.
// After rst or a size write, items are taken only once the geometry unit has finished its search and division.
// Reset clears all slab tables; the freed-slot stack memory needs no clearing.
module slab_object_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [21:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // kind[1:0], slab_index[5:2], object_index[14:6]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status, granted_slab, granted_object, byte_offset, order_in_use
);

  logic [soa_pkg::SizeW-1:0] obj_size;
  soa_pkg::geom_t            geom;
  logic                      busy, done;
  logic [1:0]                r_status;
  logic [soa_pkg::SlabW-1:0] r_slab;
  logic [soa_pkg::ObjW-1:0]  r_obj;
  logic [soa_pkg::SizeW-1:0] r_off;
  logic                      start;

  soa_geom u_geom (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .obj_size(obj_size), .geom(geom)
  );

  // hold off while the finished result is still on its way into the output register
  assign s_tready = geom.valid && !busy && !done && !m_tvalid && !cfg_we;
  assign start    = s_tvalid && s_tready;

  soa_core u_core (
    .clk(clk), .rst(rst), .clear(cfg_we), .obj_size(obj_size), .geom(geom),
    .start(start), .in_kind(s_tdata[1:0]), .in_slab(s_tdata[5:2]), .in_obj(s_tdata[14:6]),
    .busy(busy), .done(done), .r_status(r_status), .r_slab(r_slab), .r_obj(r_obj),
    .r_off(r_off)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, geom.order, r_off, r_obj, r_slab, r_status};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    done |-> !m_tvalid) else $error("result while output busy");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("core did not start");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("beat dropped");

endmodule

FILE: sim/slab_object_allocator_tb.sv
// Stream-level testbench for the slab object allocator with a built-in allocation predictor.
module slab_object_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import soa_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [21:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  typedef struct packed {
    logic [3:0]  order;
    logic [21:0] offset;
    logic [8:0]  obj;
    logic [3:0]  slab;
    logic [1:0]  status;
  } grant_t;

  slab_object_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [21:0] obj_size;
  logic [3:0]  pool_order;
  int          objs_per;
  class_t      cls [NumSlabs];
  int          nfree [NumSlabs];
  int          fresh [NumSlabs];
  int          depth [NumSlabs];
  int          stack_mem [NumSlabs][MaxObjs];
  int          nxt [NumSlabs];
  int          prv [NumSlabs];
  int          head;

  logic [15:0] pending_ops[$];
  grant_t      expected_grants[$];
  int          errors = 0;
  longint      cycles = 0;

  function automatic void derive_geometry();
    longint need;
    longint cnt;
    int i;
    need = (longint'(obj_size) + 8) * 256 + 32;
    i = 0;
    while (i < MaxOrder && (longint'(4096) << i) <= need) i++;
    pool_order = 4'(i);
    cnt = ((longint'(4096) << i) - 32) / (longint'(obj_size) + 8);
    if (cnt > MaxObjs) cnt = MaxObjs;
    objs_per = int'(cnt);
  endfunction

  function automatic void clear_pool();
    for (int s = 0; s < NumSlabs; s++) begin
      cls[s] = CL_UNUSED; nfree[s] = 0; fresh[s] = 0; depth[s] = 0;
      nxt[s] = NumSlabs; prv[s] = NumSlabs;
    end
    head = NumSlabs;
  endfunction

  function automatic void unlink(int s);
    int p, n;
    p = prv[s]; n = nxt[s];
    if (p < NumSlabs) nxt[p] = n;
    else if (head == s) head = n;
    if (n < NumSlabs) prv[n] = p;
    nxt[s] = NumSlabs; prv[s] = NumSlabs;
  endfunction

  function automatic void link_head(int s);
    prv[s] = NumSlabs; nxt[s] = head;
    if (head < NumSlabs) prv[head] = s;
    head = s;
  endfunction

  function automatic grant_t predict_grant(logic [15:0] op);
    grant_t r;
    kind_t kd;
    int si, oi, s, go;
    bit ok;
    kd = kind_t'(op[1:0]); si = op[5:2]; oi = op[14:6];
    r = '0;
    r.order = pool_order;
    case (kd)
      KIND_ALLOC: begin
        go = 0;
        if (objs_per == 0) begin
          r.status = ST_NO_SLAB;
        end else if (head < NumSlabs) begin
          s = head;
          if (depth[s] > 0) begin
            depth[s]--; go = stack_mem[s][depth[s]];
          end else begin
            go = fresh[s]; fresh[s]++;
          end
          nfree[s]--;
          r.slab = 4'(s);
          if (nfree[s] == 0) begin
            unlink(s); cls[s] = CL_FULL;
          end
        end else begin
          for (s = 0; s < NumSlabs && cls[s] != CL_UNUSED; s++) ;
          if (s >= NumSlabs) begin
            r.status = ST_NO_SLAB;
          end else begin
            depth[s] = 0; fresh[s] = 1; nfree[s] = objs_per - 1;
            r.slab = 4'(s);
            if (nfree[s] == 0) cls[s] = CL_FULL;
            else begin
              cls[s] = CL_PARTIAL; link_head(s);
            end
          end
        end
        if (r.status == ST_OK) begin
          r.obj = 9'(go);
          r.offset = 22'(40 + longint'(go) * (longint'(obj_size) + 8));
        end
      end
      KIND_FREE: begin
        ok = (cls[si] == CL_PARTIAL || cls[si] == CL_FULL) && oi < objs_per && oi < fresh[si];
        if (ok)
          for (int k = 0; k < depth[si]; k++)
            if (stack_mem[si][k] == oi) ok = 0;
        if (!ok || depth[si] >= MaxObjs) begin
          r.status = ST_BAD;
        end else begin
          stack_mem[si][depth[si]] = oi;
          depth[si]++; nfree[si]++;
          if (nfree[si] >= objs_per) begin
            if (cls[si] == CL_PARTIAL) unlink(si);
            cls[si] = CL_EMPTY;
          end else if (nfree[si] == 1) begin
            if (cls[si] == CL_PARTIAL) unlink(si);
            cls[si] = CL_PARTIAL; link_head(si);
          end
        end
      end
      KIND_SHRINK: begin
        for (s = 0; s < NumSlabs; s++)
          if (cls[s] == CL_EMPTY) begin
            cls[s] = CL_UNUSED; nfree[s] = 0; fresh[s] = 0; depth[s] = 0;
          end
      end
      default: clear_pool();
    endcase
    return r;
  endfunction

  // driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_grants.push_back(predict_grant(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          s_tdata <= pending_ops.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(12, 1);
            if ($urandom_range(3, 0) != 0) gap_left <= $urandom_range(6, 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor with its own stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    grant_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = grant_t'(m_tdata[40:0]);
        if (expected_grants.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected beat %h", m_tdata);
        end else begin
          want = expected_grants.pop_front();
          if (got !== want || m_tdata[47:41] !== '0) begin
            errors <= errors + 1;
            if (errors < 10)
              $display({"mismatch: exp st=%0d slab=%0d obj=%0d off=%0d ord=%0d, ",
                        "got st=%0d slab=%0d obj=%0d off=%0d ord=%0d"},
                       want.status, want.slab, want.obj, want.offset, want.order,
                       got.status, got.slab, got.obj, got.offset, got.order);
          end
        end
      end
      if ((cycles % 400) == 0) stall_mode <= $urandom_range(2, 0);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(3, 0) != 0);
        default: m_tready <= ((cycles % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycles > 10000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] pack_op(kind_t kd, int si, int oi);
    return {1'b0, 9'(oi), 4'(si), kd};
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() > 0 || s_tvalid || expected_grants.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_size(logic [21:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    obj_size = v;
    derive_geometry();
    clear_pool();
  endtask

  // random traffic: mostly allocs and frees within the slab geometry, a few shrinks and releases
  task automatic random_phase(int n);
    int live_s[$];
    int live_o[$];
    int r, j;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99, 0);
      if (r < 45) begin
        pending_ops.push_back(pack_op(KIND_ALLOC, $urandom_range(15, 0), $urandom_range(511, 0)));
      end else if (r < 88) begin
        pending_ops.push_back(pack_op(KIND_FREE, $urandom_range(15, 0),
                                      $urandom_range(objs_per > 0 ? objs_per - 1 : 0, 0)));
        if ($urandom_range(1, 0)) begin
          j = pending_ops.size() - 1;
          pending_ops[j][14:6] = 9'($urandom_range(3, 0));
          pending_ops[j][5:2] = 4'($urandom_range(3, 0));
        end
      end else if (r < 94) begin
        pending_ops.push_back(pack_op(KIND_FREE, $urandom_range(15, 0), $urandom_range(511, 0)));
      end else if (r < 98) begin
        pending_ops.push_back(pack_op(KIND_SHRINK, $urandom_range(15, 0),
                                      $urandom_range(511, 0)));
      end else begin
        pending_ops.push_back(pack_op(KIND_RELEASE, $urandom_range(15, 0),
                                      $urandom_range(511, 0)));
      end
    end
  endtask

  initial begin
    logic [21:0] sizes[6];
    obj_size = 22'd64;
    derive_geometry();
    clear_pool();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: allocs, bad frees, double free, empty, shrink, release
    for (int i = 0; i < 3; i++) pending_ops.push_back(pack_op(KIND_ALLOC, 15, 511));
    pending_ops.push_back(pack_op(KIND_FREE, 0, 511));
    pending_ops.push_back(pack_op(KIND_FREE, 5, 0));
    pending_ops.push_back(pack_op(KIND_FREE, 0, 1));
    pending_ops.push_back(pack_op(KIND_FREE, 0, 1));
    pending_ops.push_back(pack_op(KIND_FREE, 0, 10));
    pending_ops.push_back(pack_op(KIND_ALLOC, 0, 0));
    pending_ops.push_back(pack_op(KIND_FREE, 0, 0));
    pending_ops.push_back(pack_op(KIND_FREE, 0, 1));
    pending_ops.push_back(pack_op(KIND_FREE, 0, 2));
    pending_ops.push_back(pack_op(KIND_FREE, 0, 2));
    pending_ops.push_back(pack_op(KIND_SHRINK, 0, 0));
    pending_ops.push_back(pack_op(KIND_ALLOC, 0, 0));
    pending_ops.push_back(pack_op(KIND_RELEASE, 0, 0));
    wait_drained();

    // one object per slab: exhaust pool
    write_size(22'd4194264);
    for (int i = 0; i < 17; i++) pending_ops.push_back(pack_op(KIND_ALLOC, 0, 0));
    pending_ops.push_back(pack_op(KIND_FREE, 3, 0));
    pending_ops.push_back(pack_op(KIND_ALLOC, 0, 0));
    wait_drained();

    sizes = '{22'd1, 22'd64, 22'd100, 22'd4000, 22'd300000, 22'h3FFFFF};
    for (int p = 0; p < 6; p++) begin
      write_size(sizes[p]);
      random_phase(p == 1 ? 350 : 230);
      wait_drained();
    end
    write_size(22'($urandom_range(2000, 1)));
    random_phase(120);
    wait_drained();

    if (errors == 0 && expected_grants.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/soa_pkg.sv
design/soa_geom.sv
design/soa_core.sv
design/slab_object_allocator.sv
sim/slab_object_allocator_tb.sv
